/* design/gsc_pkg.sv */
`default_nettype none
package gsc_pkg;

	localparam int SLOTS  = 8;
	localparam int GLYPHS = 64;
	localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	localparam logic [7:0] EMPTY_CODE = 8'h7F;
	localparam logic [7:0] USED_BIT   = 8'h80;

	typedef enum logic [1:0] {
		FUNC_PRINT = 2'd0,
		FUNC_AGE   = 2'd1,
		FUNC_INVAL = 2'd2,
		FUNC_NOP   = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		CMD_HOLD,
		CMD_SHIFT,
		CMD_AGE,
		CMD_CLEAR,
		CMD_LOAD
	} cell_cmd_t;

	typedef logic [7:0] entry_t;

endpackage
`default_nettype wire

/* design/gsc_cell.sv */
`default_nettype none
module gsc_cell
	import gsc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cell_cmd_t cmd,
	input  wire entry_t    shift_in,
	input  wire entry_t    load_data,
	output entry_t         entry
);

	entry_t entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= EMPTY_CODE;
		end else begin
			unique case (cmd)
				CMD_HOLD:  entry_q <= entry_q;
				CMD_SHIFT: entry_q <= shift_in;
				CMD_AGE: begin
					if (entry_q == EMPTY_CODE) begin
						entry_q <= entry_q;
					end else if ((entry_q & USED_BIT) != 8'h00) begin
						entry_q <= entry_q & ~USED_BIT;
					end else begin
						entry_q <= EMPTY_CODE;
					end
				end
				CMD_CLEAR: entry_q <= EMPTY_CODE;
				CMD_LOAD:  entry_q <= load_data;
				default:   entry_q <= entry_q;
			endcase
		end
	end

	assign entry = entry_q;

endmodule
`default_nettype wire

/* design/glyph_slot_cache_unit.sv */
// Print with a glyph in range: the slot ring is scanned in ST_SCAN, then ST_RESULT
// registers the result once the output is free; no new request is taken until then.
// Print with a glyph out of range: goes straight to ST_RESULT without a scan.
// Frame start and invalidate: applied at acceptance, no result.
// The scan rotates the slot ring one cell per cycle past its head.
// Reset (arst_n low) empties every slot and drops any pending transaction.
`default_nettype none
module glyph_slot_cache_unit
	import gsc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] func,
	input  wire logic [6:0] glyph_code,
	input  wire logic [7:0] alternate_code,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      send_code,
	output logic            load_glyph,
	output logic [2:0]      glyph_slot
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESULT
	} state_t;

	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(SLOTS - 1);
	localparam logic [7:0]       GLYPH_LIM = 8'(GLYPHS);

	state_t           state_q;
	logic [IDX_W-1:0] cnt_q;
	logic [6:0]       glyph_q;
	logic [7:0]       alt_q;
	logic             bad_q;
	logic             found_q;
	logic             hit_q;
	logic [IDX_W-1:0] idx_q;
	logic             spare_ok_q;
	logic [IDX_W-1:0] spare_q;
	logic             out_valid_q;
	logic [7:0]       send_code_q;
	logic             load_glyph_q;
	logic [2:0]       glyph_slot_q;

	entry_t    slot_e [SLOTS];
	cell_cmd_t cmd    [SLOTS];
	logic [SLOTS-1:0] load_vec;

	logic             accept;
	logic             glyph_bad;
	logic             head_hit;
	logic             head_empty;
	logic             head_free;
	logic             wr_en;
	logic             wr_load;
	logic [IDX_W-1:0] wr_idx;
	logic [7:0]       wr_idx8;
	logic             out_free;
	entry_t           new_entry;

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign glyph_bad  = ({1'b0, glyph_code} >= GLYPH_LIM) || (glyph_code == 7'h7F);
	assign head_hit   = (slot_e[0][6:0] == glyph_q);
	assign head_empty = (slot_e[0] == EMPTY_CODE);
	assign head_free  = !slot_e[0][7];
	assign out_free   = !out_valid_q || out_ready;
	assign new_entry  = USED_BIT | {1'b0, glyph_q};

	always_comb begin
		wr_en   = 1'b0;
		wr_load = 1'b0;
		wr_idx  = '0;
		if (!bad_q) begin
			if (found_q) begin
				wr_en   = 1'b1;
				wr_load = !hit_q;
				wr_idx  = idx_q;
			end else if (spare_ok_q) begin
				wr_en   = 1'b1;
				wr_load = 1'b1;
				wr_idx  = spare_q;
			end
		end
	end

	assign wr_idx8 = 8'(wr_idx);

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			load_vec[i] = (state_q == ST_RESULT) && wr_en && (wr_idx == IDX_W'(i));
			cmd[i] = CMD_HOLD;
			if (state_q == ST_SCAN) begin
				cmd[i] = CMD_SHIFT;
			end else if (load_vec[i]) begin
				cmd[i] = CMD_LOAD;
			end else if (accept && func == FUNC_AGE) begin
				cmd[i] = CMD_AGE;
			end else if (accept && func == FUNC_INVAL) begin
				cmd[i] = CMD_CLEAR;
			end
		end
	end

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		gsc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd[i]),
			.shift_in  (slot_e[(i + 1) % SLOTS]),
			.load_data (new_entry),
			.entry     (slot_e[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			glyph_q      <= '0;
			alt_q        <= '0;
			bad_q        <= 1'b0;
			found_q      <= 1'b0;
			hit_q        <= 1'b0;
			idx_q        <= '0;
			spare_ok_q   <= 1'b0;
			spare_q      <= '0;
			out_valid_q  <= 1'b0;
			send_code_q  <= '0;
			load_glyph_q <= 1'b0;
			glyph_slot_q <= '0;
		end else begin
			if (out_valid_q && out_ready && state_q != ST_RESULT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && func == FUNC_PRINT) begin
						glyph_q    <= glyph_code;
						alt_q      <= alternate_code;
						bad_q      <= glyph_bad;
						found_q    <= 1'b0;
						hit_q      <= 1'b0;
						idx_q      <= '0;
						spare_ok_q <= 1'b0;
						spare_q    <= '0;
						cnt_q      <= '0;
						state_q    <= glyph_bad ? ST_RESULT : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (!found_q) begin
						if (head_hit) begin
							found_q <= 1'b1;
							hit_q   <= 1'b1;
							idx_q   <= cnt_q;
						end else if (head_empty) begin
							found_q <= 1'b1;
							idx_q   <= cnt_q;
						end else if (head_free) begin
							spare_ok_q <= 1'b1;
							spare_q    <= cnt_q;
						end
					end
					if (cnt_q == LAST_IDX) begin
						cnt_q   <= '0;
						state_q <= ST_RESULT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_RESULT: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						send_code_q  <= wr_en ? wr_idx8 : alt_q;
						load_glyph_q <= wr_load;
						glyph_slot_q <= wr_load ? wr_idx8[2:0] : 3'd0;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign send_code  = send_code_q;
	assign load_glyph = load_glyph_q;
	assign glyph_slot = glyph_slot_q;

	a_ring_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESULT) |-> (cnt_q == '0))
		else $error("slot ring not aligned at result");

	a_single_write: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(load_vec))
		else $error("more than one slot written");

	a_print_scans: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && func == FUNC_PRINT && !glyph_bad) |=> (state_q == ST_SCAN))
		else $error("print with valid glyph did not start a scan");

	a_load_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && load_glyph_q) |-> (send_code_q[2:0] == glyph_slot_q))
		else $error("loaded slot differs from sent code");

endmodule
`default_nettype wire
